### hdl/bafl_pkg.sv
package bafl_pkg;

  // Sensor geometry and neighborhood size.
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 512;
  localparam int MAX_RADIUS  = 3;

  // Derived widths.
  localparam int COL_W    = $clog2(MAX_COLUMNS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int WIDTH_W  = $clog2(MAX_COLUMNS + 1);
  localparam int HEIGHT_W = $clog2(MAX_ROWS + 1);
  localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
  localparam int OFS_W    = RAD_W + 1;
  localparam int PIXELS   = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(PIXELS);
  localparam int TIME_W   = 32;

  // Configuration port and register widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_RAD_W  = 2;
  localparam int CFG_COLS_W = 11;
  localparam int CFG_ROWS_W = 10;

  // Register reset values.
  localparam logic [TIME_W-1:0]     WINDOW_RST  = 32'd1000;
  localparam logic [CFG_RAD_W-1:0]  RADIUS_RST  = 2'd1;
  localparam logic [CFG_COLS_W-1:0] COLUMNS_RST = 11'd640;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RST    = 10'd480;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_WINDOW = 2'd0,
    REG_RADIUS      = 2'd1,
    REG_COLUMNS     = 2'd2,
    REG_ROWS        = 2'd3
  } cfg_reg_e;

  // Effective configuration, already saturated to the sensor limits.
  typedef struct packed {
    logic [TIME_W-1:0]   window;
    logic [RAD_W-1:0]    radius;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
  } cfg_t;

  // One entry of the per-pixel store.
  typedef struct packed {
    logic              seen;
    logic [TIME_W-1:0] stamp;
  } mem_word_t;

  // Access request from the sequencer to the pixel memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    mem_word_t         wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Result word.
  typedef struct packed {
    logic keep;
    logic bad;
  } res_t;

endpackage

### hdl/bafl_ram.sv
module bafl_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 524288
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Simple dual-port memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/bafl_scan.sv
module bafl_scan import bafl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [COL_W-1:0]  col_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [TIME_W-1:0] time_i,
  output mem_req_t          mem_o,
  input  mem_word_t         rdata_i,
  output logic              done_o,
  output res_t              res_o,
  input  logic              take_i
);

  localparam int XW = COL_W + 2;
  localparam int YW = ROW_W + 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        clr_q, clr_d;
  logic signed [OFS_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [COL_W-1:0]         col_q, col_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic [TIME_W-1:0]        thr_q, thr_d;
  logic                     nofloor_q, nofloor_d;
  logic                     keep_q, keep_d;
  logic                     bad_q, bad_d;
  logic                     rd_pend_q, rd_pend_d;

  logic                     accept;
  logic                     in_bad;
  logic signed [OFS_W-1:0]  rad_s;
  logic signed [XW-1:0]     nx;
  logic signed [YW-1:0]     ny;
  logic                     in_bounds;
  logic                     center;
  logic                     hit;

  // Linear pixel address, row major.
  function automatic logic [ADDR_W-1:0] pixel_addr(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
    return ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
  endfunction

  // Input checks and the neighbor position under test.
  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign in_bad = (WIDTH_W'(col_i) >= cfg_i.width) || (HEIGHT_W'(row_i) >= cfg_i.height);
  assign rad_s  = $signed({1'b0, cfg_i.radius});
  assign nx     = $signed({2'b00, col_q}) + XW'(dx_q);
  assign ny     = $signed({2'b00, row_q}) + YW'(dy_q);
  assign center = (dx_q == '0) && (dy_q == '0);
  assign in_bounds = !nx[XW-1] && !ny[YW-1]
                     && (32'(nx[XW-2:0]) < 32'(cfg_i.width))
                     && (32'(ny[YW-2:0]) < 32'(cfg_i.height));

  // A neighbor supports the event when it was seen and is recent enough.
  assign hit = rd_pend_q && rdata_i.seen && (nofloor_q || (rdata_i.stamp >= thr_q));

  // Memory traffic: clearing pass, the event's own write, neighbor reads.
  always_comb begin
    mem_o.we    = (state_q == ST_CLEAR) || (accept && !in_bad);
    mem_o.waddr = (state_q == ST_CLEAR) ? clr_q : pixel_addr(col_i, row_i);
    mem_o.wdata = (state_q == ST_CLEAR) ? '0 : mem_word_t'{seen: 1'b1, stamp: time_i};
    mem_o.re    = (state_q == ST_SCAN) && in_bounds && !center;
    mem_o.raddr = pixel_addr(nx[COL_W-1:0], ny[ROW_W-1:0]);
  end

  // Sequencer next state.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    col_d     = col_q;
    row_d     = row_q;
    thr_d     = thr_q;
    nofloor_d = nofloor_q;
    keep_d    = keep_q | hit;
    bad_d     = bad_q;
    rd_pend_d = mem_o.re;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(PIXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          col_d     = col_i;
          row_d     = row_i;
          thr_d     = time_i - cfg_i.window;
          nofloor_d = time_i < cfg_i.window;
          dx_d      = -rad_s;
          dy_d      = -rad_s;
          keep_d    = 1'b0;
          bad_d     = in_bad;
          state_d   = in_bad ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (dx_q == rad_s) begin
          dx_d = -rad_s;
          if (dy_q == rad_s) begin
            state_d = ST_DRAIN;
          end else begin
            dy_d = dy_q + $signed(OFS_W'(1));
          end
        end else begin
          dx_d = dx_q + $signed(OFS_W'(1));
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      col_q     <= '0;
      row_q     <= '0;
      thr_q     <= '0;
      nofloor_q <= 1'b0;
      keep_q    <= 1'b0;
      bad_q     <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      col_q     <= col_d;
      row_q     <= row_d;
      thr_q     <= thr_d;
      nofloor_q <= nofloor_d;
      keep_q    <= keep_d;
      bad_q     <= bad_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign done_o     = (state_q == ST_DONE);
  assign res_o      = '{keep: keep_q, bad: bad_q};

endmodule

### hdl/event_background_activity_filter_core.sv
// Background-activity filter for event-camera events. Each accepted word (column, row,
// microsecond timestamp) is stamped into a per-pixel memory and then kept only if another
// pixel within the square neighborhood of the configured radius holds a stamp no older than
// the time window; a coordinate outside the active size is flagged bad and not stored.
// The neighborhood is walked one position per cycle through the single read port of the
// pixel memory, so an event in range passes through the scan and drain states, while a bad
// coordinate goes straight to the done state. After reset the block runs a clearing pass
// over the pixel memory and holds in_stall_o high until it ends; configuration writes
// are taken at any time but must only be issued while the block is idle.
module event_background_activity_filter_core import bafl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Event input.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COL_W-1:0]      pixel_column_i,
  input  logic [ROW_W-1:0]      pixel_row_i,
  input  logic [TIME_W-1:0]     event_time_i,
  // Result output.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  keep_event_o,
  output logic                  bad_coordinate_o,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [TIME_W-1:0]     window_q;
  logic [CFG_RAD_W-1:0]  radius_q;
  logic [CFG_COLS_W-1:0] columns_q;
  logic [CFG_ROWS_W-1:0] rows_q;
  cfg_t                  cfg;

  mem_req_t              mem_req;
  mem_word_t             mem_rdata;
  logic                  scan_done;
  res_t                  scan_res;
  logic                  res_load;

  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_RST;
      radius_q  <= RADIUS_RST;
      columns_q <= COLUMNS_RST;
      rows_q    <= ROWS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TIME_WINDOW: window_q  <= cfg_data_i;
        REG_RADIUS:      radius_q  <= cfg_data_i[CFG_RAD_W-1:0];
        REG_COLUMNS:     columns_q <= cfg_data_i[CFG_COLS_W-1:0];
        REG_ROWS:        rows_q    <= cfg_data_i[CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the register values to the sensor limits.
  always_comb begin
    cfg.window = window_q;
    cfg.radius = (32'(radius_q) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_q);
    cfg.width  = (32'(columns_q) > 32'(MAX_COLUMNS)) ? WIDTH_W'(MAX_COLUMNS)
                                                      : WIDTH_W'(columns_q);
    cfg.height = (32'(rows_q) > 32'(MAX_ROWS)) ? HEIGHT_W'(MAX_ROWS) : HEIGHT_W'(rows_q);
  end

  // Neighborhood sequencer.
  bafl_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .col_i      (pixel_column_i),
    .row_i      (pixel_row_i),
    .time_i     (event_time_i),
    .mem_o      (mem_req),
    .rdata_i    (mem_rdata),
    .done_o     (scan_done),
    .res_o      (scan_res),
    .take_i     (res_load)
  );

  // Per-pixel seen bit and timestamp.
  bafl_ram #(
    .WIDTH ($bits(mem_word_t)),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Output register; the next event may be accepted while a result waits here.
  assign res_load = scan_done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= scan_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign keep_event_o     = out_res_q.keep;
  assign bad_coordinate_o = out_res_q.bad;

  // The pixel memory is never written and read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("pixel memory written and read in the same cycle");

  // An accepted event closes the input until its result is produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted two cycles in a row");

  // A dropped coordinate is never reported as kept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> !(keep_event_o && bad_coordinate_o))
    else $error("result both kept and flagged bad");

  // A read is only issued while an event is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |-> (in_stall_o && !scan_done))
    else $error("neighbor read outside an event");

endmodule

### bench/event_filter_checker.sv
// Watches the event, result and configuration channels of the filter. It keeps its own
// copy of the per-pixel stamps and of the registers, predicts the verdict of every
// accepted event word and compares it with the result words in arrival order.
module event_filter_checker import bafl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [COL_W-1:0]      pixel_column_i,
  input  logic [ROW_W-1:0]      pixel_row_i,
  input  logic [TIME_W-1:0]     event_time_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  keep_event_i,
  input  logic                  bad_coordinate_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    outstanding_o,
  output int                    fail_count_o
);

  // Register copies as written, before any saturation.
  logic [TIME_W-1:0]     window_q;
  logic [CFG_RAD_W-1:0]  radius_q;
  logic [CFG_COLS_W-1:0] columns_q;
  logic [CFG_ROWS_W-1:0] rows_q;

  // A pixel has an entry here only once an event has been stored at it.
  logic [TIME_W-1:0] pixel_stamps [int unsigned];

  res_t expected_verdicts [$];
  res_t want;
  int   fail_count = 0;

  // Stores the event's stamp and decides whether a recent neighbor supports it.
  function automatic res_t filter_event(input logic [COL_W-1:0] col,
                                        input logic [ROW_W-1:0] row,
                                        input logic [TIME_W-1:0] stamp);
    int                col_limit;
    int                row_limit;
    int                reach;
    int                dx;
    int                dy;
    int                nx;
    int                ny;
    int unsigned       spot;
    logic              open_floor;
    logic [TIME_W-1:0] floor_time;
    res_t              verdict;
    col_limit = (int'(columns_q) > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_q);
    row_limit = (int'(rows_q) > MAX_ROWS) ? MAX_ROWS : int'(rows_q);
    reach     = (int'(radius_q) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
    verdict   = '0;
    // Out-of-range coordinates are flagged and leave the store untouched.
    if (int'(col) >= col_limit || int'(row) >= row_limit) begin
      verdict.bad = 1'b1;
      return verdict;
    end
    pixel_stamps[int'(row) * MAX_COLUMNS + int'(col)] = stamp;
    // When the window reaches below zero every seen neighbor counts.
    open_floor = stamp < window_q;
    floor_time = open_floor ? '0 : stamp - window_q;
    for (dy = -reach; dy <= reach; dy++) begin
      for (dx = -reach; dx <= reach; dx++) begin
        nx = int'(col) + dx;
        ny = int'(row) + dy;
        if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < col_limit &&
            ny < row_limit) begin
          spot = ny * MAX_COLUMNS + nx;
          if (pixel_stamps.exists(spot) && (open_floor || pixel_stamps[spot] >= floor_time)) begin
            verdict.keep = 1'b1;
          end
        end
      end
    end
    return verdict;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  = WINDOW_RST;
      radius_q  = RADIUS_RST;
      columns_q = COLUMNS_RST;
      rows_q    = ROWS_RST;
      pixel_stamps.delete();
      expected_verdicts.delete();
      outstanding_o <= 0;
      fail_count_o  <= fail_count;
    end else begin
      // Retire the oldest prediction against each result word.
      if (out_valid_i && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with no event pending: keep_event=%0b bad_coordinate=%0b",
                 keep_event_i, bad_coordinate_i);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (keep_event_i !== want.keep) begin
            $error("keep_event: expected %0b, actual %0b", want.keep, keep_event_i);
            fail_count++;
          end
          if (bad_coordinate_i !== want.bad) begin
            $error("bad_coordinate: expected %0b, actual %0b", want.bad, bad_coordinate_i);
            fail_count++;
          end
        end
      end
      // Track register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TIME_WINDOW: window_q = cfg_data_i;
          REG_RADIUS:      radius_q = cfg_data_i[CFG_RAD_W-1:0];
          REG_COLUMNS:     columns_q = cfg_data_i[CFG_COLS_W-1:0];
          REG_ROWS:        rows_q = cfg_data_i[CFG_ROWS_W-1:0];
          default: ;
        endcase
      end
      // Predict each accepted event word.
      if (in_valid_i && !in_stall_i) begin
        expected_verdicts.push_back(filter_event(pixel_column_i, pixel_row_i, event_time_i));
      end
      outstanding_o <= expected_verdicts.size();
      fail_count_o  <= fail_count;
    end
  end

endmodule

### bench/tb_event_background_activity_filter_core.sv
module tb_event_background_activity_filter_core;
  import bafl_pkg::*;

  // The limit must also cover the quiet clearing pass after reset, about four times over.
  localparam int WATCHDOG_LIMIT   = 2_200_000;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int DRAIN_CYCLES     = 64;
  localparam int RANDOM_PHASES    = 8;
  localparam int EVENTS_PER_PHASE = 54;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COL_W-1:0]      pixel_column = '0;
  logic [ROW_W-1:0]      pixel_row = '0;
  logic [TIME_W-1:0]     event_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  keep_event;
  logic                  bad_coordinate;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int outstanding;
  int fail_count;
  int burst_left = 0;
  int idle_cycles = 0;
  int active_cols = 640;
  int active_rows = 480;
  bit hold_off_req = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  event_background_activity_filter_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pixel_column_i   (pixel_column),
    .pixel_row_i      (pixel_row),
    .event_time_i     (event_time),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .keep_event_o     (keep_event),
    .bad_coordinate_o (bad_coordinate),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  event_filter_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pixel_column_i   (pixel_column),
    .pixel_row_i      (pixel_row),
    .event_time_i     (event_time),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .keep_event_i     (keep_event),
    .bad_coordinate_i (bad_coordinate),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .outstanding_o    (outstanding),
    .fail_count_o     (fail_count)
  );

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: stall patterns of random length and density, plus one long
  // hold-off on request so that the block backs up into its input.
  initial begin : receiver
    int mode_left;
    int stall_pct;
    bit held;
    mode_left = 0;
    stall_pct = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2:    stall_pct = 25;
          3:    stall_pct = 50;
          default: stall_pct = 90;
        endcase
        mode_left = $urandom_range(5, 80);
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Writes one register and waits for the write to be taken; the caller lowers valid.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Programs all four registers; only called while nothing is in flight.
  task automatic program_filter(input logic [TIME_W-1:0] window, input int unsigned radius,
                                input int unsigned cols, input int unsigned rows);
    write_reg(REG_TIME_WINDOW, window);
    write_reg(REG_RADIUS, radius);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    cfg_valid   <= 1'b0;
    active_cols = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
    active_rows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
  endtask

  // Offers one event word in bursts of random length with random gaps between them.
  task automatic feed_event(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input logic [TIME_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
      if (gap > 0) begin
        if (in_valid) in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    pixel_column <= col;
    pixel_row    <= row;
    event_time   <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every result word has come back.
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                phase;
    int                n;
    int                spread;
    int                center_col;
    int                center_row;
    int                col;
    int                row;
    int unsigned       step_max;
    int unsigned       cols;
    int unsigned       rows;
    logic [TIME_W-1:0] window;
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] stamp;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Full sensor: history, own pixel, corners, backward time and the window edge.
    program_filter(32'd1000, 1, 1024, 512);
    feed_event(0, 0, 32'd0);
    feed_event(1, 0, 32'd5);
    feed_event(500, 300, 32'd10);
    feed_event(500, 300, 32'd20);
    feed_event(1023, 511, 32'hFFFF_FFF0);
    feed_event(1022, 510, 32'hFFFF_FFFF);
    feed_event(1021, 509, 32'd5000);
    feed_event(200, 100, 32'd10000);
    feed_event(201, 100, 32'd20000);
    feed_event(300, 100, 32'd10000);
    feed_event(301, 100, 32'd11000);
    feed_event(400, 100, 32'd10000);
    feed_event(401, 100, 32'd11001);

    // Zero window, widest radius, sizes above the sensor limits.
    settle();
    program_filter(32'd0, 3, 2047, 1023);
    feed_event(600, 200, 32'd50000);
    feed_event(603, 203, 32'd50000);
    feed_event(607, 200, 32'd50000);

    // Widest window on a single-pixel sensor with radius zero.
    settle();
    program_filter(32'hFFFF_FFFF, 0, 1, 1);
    feed_event(0, 0, 32'd7);
    feed_event(1, 0, 32'd7);
    feed_event(0, 1, 32'd7);

    // Zero size makes every coordinate bad.
    settle();
    program_filter(32'hFFFF_FFFF, 2, 0, 0);
    feed_event(0, 0, 32'd1);

    // Small sensor where the neighborhood is clipped by the far edges.
    settle();
    program_filter(32'hFFFF_FFFF, 2, 16, 8);
    feed_event(3, 3, 32'd1);
    feed_event(5, 5, 32'd2);
    feed_event(15, 7, 32'd3);
    feed_event(16, 7, 32'd3);

    // Random phases: clustered streams under random settings, with some noise.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       window = 32'd0;
        1:       window = $urandom_range(1, 50);
        2:       window = 32'd1000;
        3:       window = $urandom_range(100, 20000);
        4:       window = $urandom;
        default: window = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 11))
        0:       cols = 0;
        1, 2:    cols = 1024;
        3, 4:    cols = $urandom_range(1025, 2047);
        5, 6:    cols = $urandom_range(1, 24);
        default: cols = $urandom_range(1, 1024);
      endcase
      case ($urandom_range(0, 11))
        0:       rows = 0;
        1, 2:    rows = 512;
        3, 4:    rows = $urandom_range(513, 1023);
        5, 6:    rows = $urandom_range(1, 16);
        default: rows = $urandom_range(1, 512);
      endcase
      case ($urandom_range(0, 3))
        0:       step_max = 3;
        1:       step_max = 300;
        2:       step_max = 5000;
        default: step_max = 200000;
      endcase
      settle();
      program_filter(window, (phase == 0) ? 3 : $urandom_range(0, 3), cols, rows);

      spread = $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) begin
        center_col = $urandom_range(0, 1) ? 0 : active_cols - 1;
        center_row = $urandom_range(0, 1) ? 0 : active_rows - 1;
      end else begin
        center_col = $urandom_range(0, (active_cols > 0) ? active_cols - 1 : 0);
        center_row = $urandom_range(0, (active_rows > 0) ? active_rows - 1 : 0);
      end
      clock_now = $urandom;

      // One phase holds the result side off while the sender keeps pushing.
      if (phase == 1) begin
        hold_off_req = 1'b1;
        burst_left   = 40;
      end

      for (n = 0; n < EVENTS_PER_PHASE; n++) begin
        case ($urandom_range(0, 15))
          0: begin
            col = $urandom;
            row = $urandom;
          end
          1: begin
            col = $urandom_range(0, 1) ? active_cols - 1 : active_cols;
            row = $urandom_range(0, 1) ? active_rows - 1 : 0;
          end
          default: begin
            col = center_col + $urandom_range(0, 2 * spread) - spread;
            row = center_row + $urandom_range(0, 2 * spread) - spread;
          end
        endcase
        if ($urandom_range(0, 19) == 0) begin
          stamp = $urandom;
        end else begin
          clock_now = clock_now + $urandom_range(0, step_max);
          stamp     = clock_now;
        end
        feed_event(COL_W'(col), ROW_W'(row), stamp);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bafl_pkg.sv
hdl/bafl_ram.sv
hdl/bafl_scan.sv
hdl/event_background_activity_filter_core.sv
bench/event_filter_checker.sv
bench/tb_event_background_activity_filter_core.sv
